// ----- design/odpal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odpal_pkg
// shared types, constants and the 4x4 bayer kernel for the palette ditherer
// ----------------------------------------------------------------------------
package odpal_pkg;

  localparam int unsigned CUBE_SIZE    = 225;
  localparam int unsigned RED_STRIDE   = 45;
  localparam int unsigned GREEN_STRIDE = 5;

  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned CUBE_W   = 8;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CUBE_W-1:0] CUBE_LAST = CUBE_W'(CUBE_SIZE - 1);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DITHER = 1'b1
  } command_t;

  // bayer kernel value by {row, column}
  function automatic logic [3:0] bayer4(input logic [PHASE_W-1:0] row,
                                        input logic [PHASE_W-1:0] col);
    logic [3:0] k;
    unique case ({row, col})
      4'd0:  k = 4'd0;
      4'd1:  k = 4'd8;
      4'd2:  k = 4'd2;
      4'd3:  k = 4'd10;
      4'd4:  k = 4'd12;
      4'd5:  k = 4'd4;
      4'd6:  k = 4'd14;
      4'd7:  k = 4'd6;
      4'd8:  k = 4'd3;
      4'd9:  k = 4'd11;
      4'd10: k = 4'd1;
      4'd11: k = 4'd9;
      4'd12: k = 4'd15;
      4'd13: k = 4'd7;
      4'd14: k = 4'd13;
      default: k = 4'd5;
    endcase
    return k;
  endfunction

endpackage

// ----- design/ordered_dither_rgb565_to_palette_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_dither_rgb565_to_palette_top
// 4x4 ordered dither of rgb565 pixels to 8-bit palette indexes
// ----------------------------------------------------------------------------
// usage: each input transaction is a load or a dither command, chosen by
// s_axis_tuser. a load writes palette_value into the palette memory at
// palette_slot (slots above 224 are dropped) and gives no output. a dither
// quantizes the pixel with the bayer kernel picked by row and column phase,
// forms the cube position r*45+g*5+b and reads the palette byte there; one
// output transaction carries the byte and the cube position.
// a dither result passes the synchronous palette read and then the output
// register before it shows on m_axis.
// throughput: one transaction per cycle unless the receiver stalls, set
// by the single-port palette memory that takes one read or one write per
// cycle. a load is visible to a dither accepted in the very next cycle.
// reset clears the pipeline valids; the palette memory is not cleared, and
// a slot must be loaded before it is read. when the receiver stalls, the
// output register and the read stage hold and s_axis_tready drops once
// both are full.
// ----------------------------------------------------------------------------
module ordered_dither_rgb565_to_palette_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel[15:0], column_phase[17:16], row_phase[19:18],
  // palette_slot[27:20], palette_value[35:28], zero fill[39:36]
  input  logic [odpal_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // color_index[7:0], cube_index[15:8]
  output logic [odpal_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [odpal_pkg::PIXEL_W-1:0] pixel;
  logic [odpal_pkg::PHASE_W-1:0] column_phase;
  logic [odpal_pkg::PHASE_W-1:0] row_phase;
  logic [odpal_pkg::SLOT_W-1:0]  palette_slot;
  logic [odpal_pkg::COLOR_W-1:0] palette_value;

  logic [3:0] k;
  logic [5:0] red_sum;
  logic [5:0] green_sum;
  logic [5:0] blue_sum;
  logic [2:0] red_lvl;
  logic [3:0] green_lvl;
  logic [2:0] blue_lvl;
  logic [8:0] cube_sum;
  logic [odpal_pkg::CUBE_W-1:0] cube;

  logic accept;
  logic is_dither;
  logic out_free;
  logic move;

  logic [odpal_pkg::COLOR_W-1:0] palette_mem [0:odpal_pkg::CUBE_SIZE-1];
  logic [odpal_pkg::COLOR_W-1:0] rd_data;

  logic                          rd_valid;
  logic [odpal_pkg::CUBE_W-1:0]  rd_cube;
  logic                          out_valid;
  logic [odpal_pkg::COLOR_W-1:0] out_color;
  logic [odpal_pkg::CUBE_W-1:0]  out_cube;

  assign pixel         = s_axis_tdata[15:0];
  assign column_phase  = s_axis_tdata[17:16];
  assign row_phase     = s_axis_tdata[19:18];
  assign palette_slot  = s_axis_tdata[27:20];
  assign palette_value = s_axis_tdata[35:28];

  // cube position of the dithered pixel
  always_comb begin
    k         = odpal_pkg::bayer4(row_phase, column_phase);
    red_sum   = {1'b0, pixel[15:11]} + {3'b000, k[3:1]};
    green_sum = {1'b0, pixel[10:6]} + {4'b0000, k[3:2]};
    blue_sum  = {1'b0, pixel[4:0]} + {3'b000, k[3:1]};
    red_lvl   = red_sum[5:3];
    green_lvl = green_sum[5:2];
    blue_lvl  = blue_sum[5:3];
    cube_sum  = 9'(red_lvl * 9'(odpal_pkg::RED_STRIDE))
              + 9'(green_lvl * 9'(odpal_pkg::GREEN_STRIDE))
              + {6'b000000, blue_lvl};
    if (cube_sum >= 9'(odpal_pkg::CUBE_SIZE)) begin
      cube = odpal_pkg::CUBE_LAST;
    end else begin
      cube = cube_sum[odpal_pkg::CUBE_W-1:0];
    end
  end

  assign out_free      = !out_valid || m_axis_tready;
  assign move          = rd_valid && out_free;
  assign s_axis_tready = !rd_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_dither     = (s_axis_tuser == odpal_pkg::CMD_DITHER);

  // palette memory, one access per cycle
  always_ff @(posedge clk) begin
    if (accept && !is_dither && (palette_slot < odpal_pkg::SLOT_W'(odpal_pkg::CUBE_SIZE))) begin
      palette_mem[palette_slot] <= palette_value;
    end
    if (accept && is_dither) begin
      rd_data <= palette_mem[cube];
      rd_cube <= cube;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (accept) begin
      rd_valid <= is_dither;
    end else if (move) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_color <= rd_data;
      out_cube  <= rd_cube;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_cube, out_color};

  // checks
  a_dither_reaches_read: assert property (@(posedge clk) disable iff (rst)
    (accept && is_dither) |=> rd_valid)
    else $error("dither transaction lost before palette read");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_dither) |=> !rd_valid)
    else $error("load transaction produced a read stage entry");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline is full");

  a_cube_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (rd_cube <= odpal_pkg::CUBE_LAST))
    else $error("cube position out of range");

  a_move_to_output: assert property (@(posedge clk) disable iff (rst)
    move |=> (out_valid && (out_cube == $past(rd_cube))))
    else $error("read stage not transferred to output register");

endmodule
